@@ rtl/ntp_to_ptp_clock_quality_defines.svh @@
// assertion macros for the clock quality mapper
`ifndef NTP_TO_PTP_CLOCK_QUALITY_DEFINES_SVH
`define NTP_TO_PTP_CLOCK_QUALITY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define N2PCQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define N2PCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/n2pcq_pkg.sv @@
// types and constants of the clock quality mapper
package n2pcq_pkg;

    typedef struct packed {
        logic               sample_valid;
        logic [7:0]         stratum;
        logic signed [7:0]  precision_log2;
        logic signed [63:0] rtt_ns;
    } t_in;

    typedef struct packed {
        logic [7:0]  quality_class;
        logic [7:0]  quality_accuracy;
        logic [15:0] scaled_log_variance;
    } t_out;

    localparam logic [7:0]  CLASS_PRIMARY   = 8'd6;
    localparam logic [7:0]  CLASS_STRAT2    = 8'd52;
    localparam logic [7:0]  CLASS_STRAT3    = 8'd58;
    localparam logic [7:0]  CLASS_LOWER     = 8'd187;
    localparam logic [7:0]  CLASS_DEFAULT   = 8'd248;
    localparam logic [7:0]  ACC_BASE        = 8'h20;
    localparam logic [7:0]  ACC_LAST        = 8'h30;
    localparam logic [7:0]  ACC_UNKNOWN     = 8'hFE;
    localparam logic [15:0] VAR_MAX         = 16'hFFFF;

    localparam int          NUM_LIMITS      = 17;
    localparam int          SQ_STEPS        = 24;
    // edges from the edge that takes an item to the edge that takes its result
    localparam int          LATENCY         = 30;

    localparam logic signed [63:0] ONE_SEC_NS = 64'sd1000000000;
    localparam logic signed [63:0] TEN_SEC_NS = 64'sd10000000000;

    // log2(1e18) in q.24, times 16384
    localparam logic [44:0] LOG_REF = 45'd1003188693 << 14;

    localparam logic signed [63:0] ACC_LIMIT [NUM_LIMITS] = '{
        64'sd25, 64'sd100, 64'sd250, 64'sd1000, 64'sd2500, 64'sd10000,
        64'sd25000, 64'sd100000, 64'sd250000, 64'sd1000000, 64'sd2500000,
        64'sd10000000, 64'sd25000000, 64'sd100000000, 64'sd250000000,
        64'sd1000000000, 64'sd10000000000
    };

endpackage

@@ rtl/ntp_to_ptp_clock_quality.sv @@
// top level: pipelined mapping of one time-server sample to a clock quality triple
//
// usage: drive i_item and raise start; an item is taken at every edge where
// start is high and busy is low. busy stays low, so an item can be taken in
// every cycle and many items are in flight at once.
// each item gives exactly one result on o_result, marked by o_strobe for one
// cycle: o_strobe rises once the item has passed every stage below and the
// output register, and items leave in the order they came in.
// throughput is one item per cycle. the depth is set by the log2 unit: one
// 32x32 squaring stage per fraction bit (24 stages), after five stages for
// the halving, magnitude, accuracy compare, top-bit search and normalizing,
// and followed by one output register.
// reset (i_rst_n low at an edge) clears every valid bit, so items in flight
// are dropped and no strobe follows until new items arrive.
// results cannot be held off by the receiver; o_strobe marks the only cycle
// in which a result can be taken.
// invalid samples leave with class 248, accuracy 0xfe, variance 0xffff.
// the block keeps no state between items.
//
`include "ntp_to_ptp_clock_quality_defines.svh"

module ntp_to_ptp_clock_quality (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  n2pcq_pkg::t_in  i_item,
    output logic            o_strobe,
    output n2pcq_pkg::t_out o_result
);
    import n2pcq_pkg::*;

    // stage 1: halve round trip, precision in ns, class
    logic               r_s1_vld, r_s1_ok;
    logic [7:0]         r_s1_class;
    logic signed [63:0] r_s1_jit, r_s1_prec;
    // stage 2: magnitude and accuracy value
    logic               r_s2_vld, r_s2_ok, r_s2_zero;
    logic [7:0]         r_s2_class;
    logic [63:0]        r_s2_mag;
    logic signed [63:0] r_s2_acc;
    // stage 3: threshold compares and per-byte top bit
    logic               r_s3_vld, r_s3_ok, r_s3_zero;
    logic [7:0]         r_s3_class;
    logic [63:0]        r_s3_mag;
    logic [NUM_LIMITS-1:0] r_s3_lt;
    logic [7:0]         r_s3_nz;
    logic [2:0]         r_s3_idx [8];
    // stage 4: exponent and accuracy code
    logic               r_s4_vld, r_s4_ok, r_s4_zero;
    logic [7:0]         r_s4_class, r_s4_acc;
    logic [63:0]        r_s4_mag;
    logic [5:0]         r_s4_exp;
    // squaring stages, entry 0 is the normalized mantissa
    logic               r_sq_vld  [SQ_STEPS+1];
    logic               r_sq_ok   [SQ_STEPS+1];
    logic               r_sq_zero [SQ_STEPS+1];
    logic [7:0]         r_sq_class[SQ_STEPS+1];
    logic [7:0]         r_sq_acc  [SQ_STEPS+1];
    logic [5:0]         r_sq_exp  [SQ_STEPS+1];
    logic [31:0]        r_sq_x    [SQ_STEPS+1];
    logic [SQ_STEPS-1:0] r_sq_frac[SQ_STEPS+1];
    // output
    logic               r_strobe;
    t_out               r_result;

    logic               accept;
    logic signed [63:0] w_rtt_adj;
    logic signed [63:0] n_s1_prec;
    logic [7:0]         n_s1_class;
    logic [7:0]         n_neg_p;
    logic [NUM_LIMITS-1:0] n_s3_lt;
    logic [7:0]         n_s3_nz;
    logic [2:0]         n_s3_idx [8];
    logic [5:0]         n_s4_exp;
    logic [7:0]         n_s4_acc;
    logic [31:0]        n_norm_x;
    logic [31:0]        n_sq_x   [SQ_STEPS];
    logic               n_sq_bit [SQ_STEPS];
    logic [63:0]        w_sq_prod[SQ_STEPS];
    logic [44:0]        w_lhs;
    logic [44:0]        w_diff;
    logic [20:0]        w_scaled;
    t_out               n_result;
    logic               w_class_ok;
    logic               w_acc_ok;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // truncate toward zero: add one to every negative before the shift
    assign w_rtt_adj = i_item.rtt_ns + $signed({63'd0, i_item.rtt_ns[63]});
    assign n_neg_p   = 8'(-i_item.precision_log2);

    always_comb begin
        if (i_item.precision_log2 >= 8'sd4) begin
            n_s1_prec = TEN_SEC_NS;
        end else if (i_item.precision_log2 >= 8'sd0) begin
            n_s1_prec = ONE_SEC_NS <<< i_item.precision_log2[1:0];
        end else if (n_neg_p >= 8'd63) begin
            n_s1_prec = '0;
        end else begin
            n_s1_prec = ONE_SEC_NS >>> n_neg_p[5:0];
        end
    end

    always_comb begin
        case (i_item.stratum) inside
            8'd1:         n_s1_class = CLASS_PRIMARY;
            8'd2:         n_s1_class = CLASS_STRAT2;
            8'd3:         n_s1_class = CLASS_STRAT3;
            [8'd4:8'd15]: n_s1_class = CLASS_LOWER;
            default:      n_s1_class = CLASS_DEFAULT;
        endcase
    end

    always_comb begin
        for (int k = 0; k < NUM_LIMITS; k++) begin
            n_s3_lt[k] = r_s2_acc < ACC_LIMIT[k];
        end
        for (int b = 0; b < 8; b++) begin
            n_s3_nz[b]  = |r_s2_mag[8*b +: 8];
            n_s3_idx[b] = '0;
            for (int j = 0; j < 8; j++) begin
                if (r_s2_mag[8*b + j]) begin
                    n_s3_idx[b] = 3'(j);
                end
            end
        end
    end

    always_comb begin
        n_s4_exp = '0;
        for (int b = 0; b < 8; b++) begin
            if (r_s3_nz[b]) begin
                n_s4_exp = {3'(b), r_s3_idx[b]};
            end
        end
        n_s4_acc = ACC_UNKNOWN;
        for (int k = NUM_LIMITS - 1; k >= 0; k--) begin
            if (r_s3_lt[k]) begin
                n_s4_acc = ACC_BASE + 8'(k);
            end
        end
    end

    // mantissa to q1.31, low bits dropped
    always_comb begin
        if (r_s4_exp > 6'd31) begin
            n_norm_x = 32'(r_s4_mag >> (r_s4_exp - 6'd31));
        end else begin
            n_norm_x = 32'(r_s4_mag << (6'd31 - r_s4_exp));
        end
    end

    // each stage squares once and yields one fraction bit
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            w_sq_prod[k] = 64'(r_sq_x[k]) * 64'(r_sq_x[k]);
            n_sq_bit[k]  = w_sq_prod[k][63];
            n_sq_x[k]    = n_sq_bit[k] ? w_sq_prod[k][63:32] : w_sq_prod[k][62:31];
        end
    end

    assign w_lhs    = {r_sq_exp[SQ_STEPS], r_sq_frac[SQ_STEPS], 15'd0};
    assign w_diff   = w_lhs - LOG_REF;
    assign w_scaled = w_diff[44:24];

    always_comb begin
        n_result.quality_class    = r_sq_class[SQ_STEPS];
        n_result.quality_accuracy = r_sq_acc[SQ_STEPS];
        if (r_sq_zero[SQ_STEPS] || (w_lhs <= LOG_REF)) begin
            n_result.scaled_log_variance = '0;
        end else if (w_scaled > 21'(VAR_MAX)) begin
            n_result.scaled_log_variance = VAR_MAX;
        end else begin
            n_result.scaled_log_variance = w_scaled[15:0];
        end
        if (!r_sq_ok[SQ_STEPS]) begin
            n_result.quality_class       = CLASS_DEFAULT;
            n_result.quality_accuracy    = ACC_UNKNOWN;
            n_result.scaled_log_variance = VAR_MAX;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_strobe <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
        end else begin
            r_s1_vld    <= accept;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= r_s3_vld;
            r_sq_vld[0] <= r_s4_vld;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            r_strobe <= r_sq_vld[SQ_STEPS];
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        r_s1_ok    <= i_item.sample_valid;
        r_s1_class <= n_s1_class;
        r_s1_jit   <= w_rtt_adj >>> 1;
        r_s1_prec  <= n_s1_prec;

        r_s2_ok    <= r_s1_ok;
        r_s2_class <= r_s1_class;
        r_s2_zero  <= (r_s1_jit == '0);
        r_s2_mag   <= r_s1_jit[63] ? 64'(-r_s1_jit) : 64'(r_s1_jit);
        r_s2_acc   <= (r_s1_prec > r_s1_jit) ? r_s1_prec : r_s1_jit;

        r_s3_ok    <= r_s2_ok;
        r_s3_class <= r_s2_class;
        r_s3_zero  <= r_s2_zero;
        r_s3_mag   <= r_s2_mag;
        r_s3_lt    <= n_s3_lt;
        r_s3_nz    <= n_s3_nz;
        r_s3_idx   <= n_s3_idx;

        r_s4_ok    <= r_s3_ok;
        r_s4_class <= r_s3_class;
        r_s4_zero  <= r_s3_zero;
        r_s4_mag   <= r_s3_mag;
        r_s4_exp   <= n_s4_exp;
        r_s4_acc   <= n_s4_acc;

        r_sq_ok[0]    <= r_s4_ok;
        r_sq_zero[0]  <= r_s4_zero;
        r_sq_class[0] <= r_s4_class;
        r_sq_acc[0]   <= r_s4_acc;
        r_sq_exp[0]   <= r_s4_exp;
        r_sq_x[0]     <= n_norm_x;
        r_sq_frac[0]  <= '0;
        for (int k = 0; k < SQ_STEPS; k++) begin
            r_sq_ok[k+1]    <= r_sq_ok[k];
            r_sq_zero[k+1]  <= r_sq_zero[k];
            r_sq_class[k+1] <= r_sq_class[k];
            r_sq_acc[k+1]   <= r_sq_acc[k];
            r_sq_exp[k+1]   <= r_sq_exp[k];
            r_sq_x[k+1]     <= n_sq_x[k];
            r_sq_frac[k+1]  <= {r_sq_frac[k][SQ_STEPS-2:0], n_sq_bit[k]};
        end

        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign w_class_ok = (o_result.quality_class == CLASS_PRIMARY) ||
                        (o_result.quality_class == CLASS_STRAT2) ||
                        (o_result.quality_class == CLASS_STRAT3) ||
                        (o_result.quality_class == CLASS_LOWER) ||
                        (o_result.quality_class == CLASS_DEFAULT);
    assign w_acc_ok   = (o_result.quality_accuracy == ACC_UNKNOWN) ||
                        ((o_result.quality_accuracy >= ACC_BASE) &&
                         (o_result.quality_accuracy <= ACC_LAST));

    `N2PCQ_ASSERT_IMPL(a_latency, o_strobe, $past(start && !busy, LATENCY), "result without item")
    `N2PCQ_ASSERT_IMPL(a_class, o_strobe, w_class_ok, "bad class")
    `N2PCQ_ASSERT_IMPL(a_acc, o_strobe, w_acc_ok, "bad accuracy")
    `N2PCQ_ASSERT_NEXT(a_no_busy, 1'b1, !busy, "busy raised")

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the ntp to ptp clock quality mapper
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import n2pcq_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 11;
    localparam int RANDOM_CNT  = 1880;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_FROM  = 800;
    localparam int QUIET_TO    = 1150;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_in  i_item  = '0;
    logic o_strobe;
    t_out o_result;

    t_in  samples_pending [$];
    t_out quality_due     [$];
    int   samples_total   = 0;
    int   samples_taken   = 0;
    int   mismatches      = 0;
    int   cycles          = 0;

    ntp_to_ptp_clock_quality dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // expected clock quality triple for one sample
    function automatic t_out quality_of(t_in s);
        t_out q;
        logic signed [63:0] jit;
        logic signed [63:0] prec_ns;
        logic signed [63:0] worst;
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] lg;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [63:0] scaled;
        int p;
        int e;
        bit found;
        q.quality_class       = CLASS_DEFAULT;
        q.quality_accuracy    = ACC_UNKNOWN;
        q.scaled_log_variance = VAR_MAX;
        if (!s.sample_valid) begin
            return q;
        end
        jit = s.rtt_ns / 64'sd2;

        case (s.stratum)
            8'd1:    q.quality_class = CLASS_PRIMARY;
            8'd2:    q.quality_class = CLASS_STRAT2;
            8'd3:    q.quality_class = CLASS_STRAT3;
            default: q.quality_class = (s.stratum == 8'd0 || s.stratum >= 8'd16)
                                       ? CLASS_DEFAULT : CLASS_LOWER;
        endcase

        p = s.precision_log2;
        if (p >= 4) begin
            prec_ns = TEN_SEC_NS;
        end else if (p >= 0) begin
            prec_ns = ONE_SEC_NS << p;
        end else begin
            prec_ns = (-p >= 63) ? 64'sd0 : ONE_SEC_NS >> (-p);
        end
        worst = (prec_ns > jit) ? prec_ns : jit;
        found = 1'b0;
        for (int k = 0; k < NUM_LIMITS; k++) begin
            if (!found && worst < ACC_LIMIT[k]) begin
                q.quality_accuracy = ACC_BASE + 8'(k);
                found = 1'b1;
            end
        end
        if (!found) begin
            q.quality_accuracy = ACC_UNKNOWN;
        end

        if (jit == 64'sd0) begin
            q.scaled_log_variance = 16'd0;
            return q;
        end
        mag = (jit < 0) ? -jit : jit;
        e = 0;
        for (int k = 63; k > 0; k--) begin
            if (e == 0 && mag[k]) begin
                e = k;
            end
        end
        x  = (e > 31) ? (mag >> (e - 31)) : (mag << (31 - e));
        lg = 64'(e) << 24;
        // one fraction bit per squaring of the q1.31 mantissa
        for (int k = 0; k < SQ_STEPS; k++) begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000) begin
                x = x >> 1;
                lg[23 - k] = 1'b1;
            end
        end
        lhs = lg << 15;
        rhs = 64'(LOG_REF);
        if (lhs <= rhs) begin
            q.scaled_log_variance = 16'd0;
        end else begin
            scaled = (lhs - rhs) >> 24;
            q.scaled_log_variance = (scaled > 64'hFFFF) ? VAR_MAX : scaled[15:0];
        end
        return q;
    endfunction

    function automatic t_in sample(logic valid, logic [7:0] strat,
                                   logic signed [7:0] prec, logic signed [63:0] rtt);
        t_in s;
        s.sample_valid   = valid;
        s.stratum        = strat;
        s.precision_log2 = prec;
        s.rtt_ns         = rtt;
        return s;
    endfunction

    // round trips spread over the interesting regions of both outputs
    function automatic logic signed [63:0] random_rtt();
        logic signed [63:0] v;
        int w;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                w = $urandom_range(0, 63);
                v = v >>> (63 - w);
            end
            2: begin
                // just around twice an accuracy threshold
                v = 2 * ACC_LIMIT[$urandom_range(0, NUM_LIMITS - 1)]
                    + $signed(64'($urandom_range(0, 6))) - 64'sd3;
            end
            3: begin
                // jitter where the variance leaves zero and reaches the clamp
                v = ONE_SEC_NS + 64'sd2 * $signed({32'd0, $urandom});
                if ($urandom_range(0, 3) == 0) begin
                    v = -v;
                end
            end
            default: v = $signed(64'($urandom_range(0, 16))) - 64'sd8;
        endcase
        return v;
    endfunction

    function automatic t_in random_sample();
        t_in s;
        s.sample_valid   = ($urandom_range(0, 9) != 0);
        s.stratum        = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 20))
                                                       : 8'($urandom);
        s.precision_log2 = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                                       : -$signed(8'($urandom_range(20, 40)));
        s.rtt_ns         = random_rtt();
        return s;
    endfunction

    function automatic bit idle_now();
        if (samples_taken >= QUIET_FROM && samples_taken < QUIET_TO) begin
            return 1'b0;
        end
        return ($urandom_range(0, 99) < 28);
    endfunction

    // driver: an item is taken at every edge with start high and busy low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                quality_due.push_back(quality_of(i_item));
                samples_taken++;
            end
            if (!start || !busy) begin
                if (samples_pending.size() > 0 && !idle_now()) begin
                    i_item <= samples_pending.pop_front();
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each strobe carries the result of the oldest item in flight
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (quality_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: class %0d acc %h var %h",
                             o_result.quality_class, o_result.quality_accuracy,
                             o_result.scaled_log_variance);
                end
            end else begin
                want = quality_due.pop_front();
                if (o_result.quality_class !== want.quality_class ||
                    o_result.quality_accuracy !== want.quality_accuracy ||
                    o_result.scaled_log_variance !== want.scaled_log_variance) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected class %0d acc %h var %h, got %0d %h %h",
                                 want.quality_class, want.quality_accuracy,
                                 want.scaled_log_variance, o_result.quality_class,
                                 o_result.quality_accuracy, o_result.scaled_log_variance);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // invalid samples, whatever the other fields hold
        samples_pending.push_back(sample(1'b0, 8'd255, -8'sd128, -64'sd1));
        samples_pending.push_back(sample(1'b0, 8'd1, 8'sd0, 64'sd0));
        // every class of stratum
        samples_pending.push_back(sample(1'b1, 8'd0, -8'sd20, 64'sd100));
        samples_pending.push_back(sample(1'b1, 8'd1, -8'sd20, 64'sd100));
        samples_pending.push_back(sample(1'b1, 8'd2, -8'sd20, 64'sd100));
        samples_pending.push_back(sample(1'b1, 8'd3, -8'sd20, 64'sd100));
        samples_pending.push_back(sample(1'b1, 8'd4, -8'sd20, 64'sd100));
        samples_pending.push_back(sample(1'b1, 8'd15, -8'sd20, 64'sd100));
        samples_pending.push_back(sample(1'b1, 8'd16, -8'sd20, 64'sd100));
        samples_pending.push_back(sample(1'b1, 8'd255, -8'sd20, 64'sd100));
        // precision extremes and the saturation points
        samples_pending.push_back(sample(1'b1, 8'd1, -8'sd128, 64'sd0));
        samples_pending.push_back(sample(1'b1, 8'd1, -8'sd62, 64'sd0));
        samples_pending.push_back(sample(1'b1, 8'd1, -8'sd1, 64'sd0));
        samples_pending.push_back(sample(1'b1, 8'd1, 8'sd3, 64'sd0));
        samples_pending.push_back(sample(1'b1, 8'd1, 8'sd4, 64'sd0));
        samples_pending.push_back(sample(1'b1, 8'd1, 8'sd127, 64'sd0));
        // zero jitter, negative jitter, threshold edges and extreme round trips
        samples_pending.push_back(sample(1'b1, 8'd2, -8'sd128, 64'sd1));
        samples_pending.push_back(sample(1'b1, 8'd2, -8'sd128, -64'sd1));
        samples_pending.push_back(sample(1'b1, 8'd2, -8'sd128, -64'sd2));
        samples_pending.push_back(sample(1'b1, 8'd2, -8'sd128, 64'sd49));
        samples_pending.push_back(sample(1'b1, 8'd2, -8'sd128, 64'sd50));
        samples_pending.push_back(sample(1'b1, 8'd3, -8'sd128, 64'sd2000000000));
        samples_pending.push_back(sample(1'b1, 8'd3, -8'sd128, -64'sd2000000000));
        samples_pending.push_back(sample(1'b1, 8'd3, -8'sd128, 64'sd19999999998));
        samples_pending.push_back(sample(1'b1, 8'd3, -8'sd128, 64'sd20000000000));
        samples_pending.push_back(sample(1'b1, 8'd4, -8'sd128, 64'h7FFF_FFFF_FFFF_FFFF));
        samples_pending.push_back(sample(1'b1, 8'd4, -8'sd128, 64'h8000_0000_0000_0000));
        for (int n = 0; n < RANDOM_CNT; n++) begin
            samples_pending.push_back(random_sample());
        end
        samples_total = samples_pending.size();

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (samples_taken < samples_total || quality_due.size() != 0) begin
            @(posedge i_clk);
        end
        // catch stray strobes after the last result
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
